// File: sv/mcv_pkg.sv
// ----------------------------------------------------------------------------
// mcv_pkg
// Shared constants, types and controller codes for the vote combiner.
// ----------------------------------------------------------------------------
package mcv_pkg;

   localparam int MAX_CLASSES = 16;
   localparam int SCORE_BITS  = 32;

   // Width of a class index, of a count that can reach MAX_CLASSES, and of
   // a vote counter (a class gets at most MAX_CLASSES-1 votes).
   localparam int CLASS_W = $clog2(MAX_CLASSES);
   localparam int COUNT_W = $clog2(MAX_CLASSES + 1);
   localparam int VOTE_W  = $clog2(MAX_CLASSES);

   localparam int SCORE_PORT_W = 32;
   localparam int RESULT_W     = 4;
   localparam int CLS_CFG_W    = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   // Register indexes on the configuration port.
   localparam logic REG_MODE        = 1'b0;
   localparam logic REG_CLASS_COUNT = 1'b1;

   // Voting modes.
   localparam logic MODE_ONE_VS_REST = 1'b0;
   localparam logic MODE_ONE_VS_ONE  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_SCAN,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic load_score;
      logic step;
      logic scan;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_item;
      logic need_scan;
      logic scan_last;
      logic out_busy;
   } dp_status_type;

endpackage

// File: sv/mcv_ctrl.sv
// ----------------------------------------------------------------------------
// mcv_ctrl
// Sequencer: takes a score, applies it, runs the vote scan and hands off
// each example's result to the output register.
// ----------------------------------------------------------------------------
module mcv_ctrl
   import mcv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (status.last_item) begin
               state_in = status.need_scan ? ST_SCAN : ST_FINISH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready      = 1'b1;
            cmd.load_score = req_valid;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = !status.out_busy || rsp_ready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: sv/mcv_datapath.sv
// ----------------------------------------------------------------------------
// mcv_datapath
// Score register, running maximum, pair counters, vote store, argmax scan
// and the result register.
// ----------------------------------------------------------------------------
module mcv_datapath
   import mcv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_cmd_type            cmd,
   input  logic                    mode,
   input  logic [CLS_CFG_W-1:0]    class_count,
   input  logic                    cfg_clear,
   input  logic [SCORE_PORT_W-1:0] req_score,
   input  logic                    rsp_ready,
   output dp_status_type           status,
   output logic                    rsp_valid,
   output logic [RESULT_W-1:0]     rsp_winner,
   output logic [RESULT_W-1:0]     rsp_top_votes
);

   logic signed [SCORE_BITS-1:0] score_ff, score_in;
   logic signed [SCORE_BITS-1:0] best_score_ff, best_score_in;
   logic [CLASS_W-1:0]           best_class_ff, best_class_in;
   logic [COUNT_W-1:0]           position_ff, position_in;
   logic [CLASS_W-1:0]           row_ff, row_in;
   logic [CLASS_W-1:0]           column_ff, column_in;
   logic [VOTE_W-1:0]            votes_ff [MAX_CLASSES];
   logic [VOTE_W-1:0]            votes_in [MAX_CLASSES];
   logic [CLASS_W-1:0]           scan_ff, scan_in;
   logic [VOTE_W-1:0]            top_ff, top_in;
   logic [CLASS_W-1:0]           scan_win_ff, scan_win_in;
   logic                         out_valid_ff, out_valid_in;
   logic [RESULT_W-1:0]          out_winner_ff, out_winner_in;
   logic [RESULT_W-1:0]          out_top_ff, out_top_in;

   logic [COUNT_W-1:0] n_use;
   logic [COUNT_W-1:0] column_next;
   logic [COUNT_W-1:0] row_plus_two;
   logic [COUNT_W-1:0] position_next;
   logic               positive;
   logic [CLASS_W-1:0] target;
   logic [CLASS_W-1:0] rd_addr;
   logic [VOTE_W-1:0]  rd_votes;
   logic               clear;

   // Class count saturates into the supported range.
   always_comb begin
      if (class_count < CLS_CFG_W'(2)) begin
         n_use = COUNT_W'(2);
      end else if (COUNT_W'(class_count) > COUNT_W'(MAX_CLASSES)
                   || class_count > CLS_CFG_W'(MAX_CLASSES)) begin
         n_use = COUNT_W'(MAX_CLASSES);
      end else begin
         n_use = COUNT_W'(class_count);
      end
   end

   assign positive      = score_ff > 0;
   assign target        = positive ? row_ff : column_ff;
   assign column_next   = COUNT_W'(column_ff) + COUNT_W'(1);
   assign row_plus_two  = COUNT_W'(row_ff) + COUNT_W'(2);
   assign position_next = position_ff + COUNT_W'(1);

   // The vote store is read at one place per cycle: the voted class while
   // stepping, the scan index while scanning.
   assign rd_addr  = cmd.scan ? scan_ff : target;
   assign rd_votes = votes_ff[rd_addr];

   assign clear = cmd.finish || cfg_clear;

   always_comb begin
      status.last_item = (mode == MODE_ONE_VS_ONE)
                         ? (column_next >= n_use && row_plus_two >= n_use)
                         : (position_next >= n_use);
      status.need_scan = (mode == MODE_ONE_VS_ONE);
      status.scan_last = (COUNT_W'(scan_ff) + COUNT_W'(1)) >= n_use;
      status.out_busy  = out_valid_ff;
   end

   always_comb begin
      score_in      = score_ff;
      best_score_in = best_score_ff;
      best_class_in = best_class_ff;
      position_in   = position_ff;
      row_in        = row_ff;
      column_in     = column_ff;
      votes_in      = votes_ff;
      scan_in       = scan_ff;
      top_in        = top_ff;
      scan_win_in   = scan_win_ff;

      if (cmd.load_score) begin
         score_in = req_score[SCORE_BITS-1:0];
      end

      if (cmd.step) begin
         if (mode == MODE_ONE_VS_ONE) begin
            votes_in[target] = rd_votes + VOTE_W'(1);
            if (column_next >= n_use) begin
               row_in    = row_ff + CLASS_W'(1);
               column_in = CLASS_W'(row_plus_two);
            end else begin
               column_in = CLASS_W'(column_next);
            end
         end else begin
            if (position_ff == '0 || score_ff > best_score_ff) begin
               best_score_in = score_ff;
               best_class_in = CLASS_W'(position_ff);
            end
            position_in = position_next;
         end
      end

      // First class with the strictly highest count wins.
      if (cmd.scan) begin
         if (scan_ff == '0 || rd_votes > top_ff) begin
            top_in      = rd_votes;
            scan_win_in = scan_ff;
         end
         scan_in = scan_ff + CLASS_W'(1);
      end

      if (clear) begin
         best_score_in = '0;
         best_class_in = '0;
         position_in   = '0;
         row_in        = '0;
         column_in     = CLASS_W'(1);
         scan_in       = '0;
         for (int i = 0; i < MAX_CLASSES; i++) begin
            votes_in[i] = '0;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_winner_in = out_winner_ff;
      out_top_in    = out_top_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
         if (mode == MODE_ONE_VS_ONE) begin
            out_winner_in = RESULT_W'(scan_win_ff);
            out_top_in    = RESULT_W'(top_ff);
         end else begin
            out_winner_in = RESULT_W'(best_class_ff);
            out_top_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_score_ff <= '0;
         best_class_ff <= '0;
         position_ff   <= '0;
         row_ff        <= '0;
         column_ff     <= CLASS_W'(1);
         scan_ff       <= '0;
         out_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_CLASSES; i++) begin
            votes_ff[i] <= '0;
         end
      end else begin
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
         position_ff   <= position_in;
         row_ff        <= row_in;
         column_ff     <= column_in;
         scan_ff       <= scan_in;
         out_valid_ff  <= out_valid_in;
         votes_ff      <= votes_in;
      end
   end

   always_ff @(posedge clock) begin
      score_ff      <= score_in;
      top_ff        <= top_in;
      scan_win_ff   <= scan_win_in;
      out_winner_ff <= out_winner_in;
      out_top_ff    <= out_top_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_winner    = out_winner_ff;
   assign rsp_top_votes = out_top_ff;

endmodule

// File: sv/multiclass_vote_combiner.sv
// ----------------------------------------------------------------------------
// multiclass_vote_combiner
// Combines binary classifier decision scores of one example into a label.
// ----------------------------------------------------------------------------
// Usage: scores enter one per transaction on the req_ channel (req_score,
// signed Q16.16), in classifier order. In one-versus-rest mode an example is
// class_count scores; in one-versus-one mode it is class_count*(class_count-1)/2
// scores in pair order (0,1),(0,2)..(1,2)... Each completed example yields one
// transaction on the rsp_ channel carrying the winning class and, in
// one-versus-one mode, its vote count.
// Sequence: each score is captured in the idle state and applied to the
// running maximum or to the vote store in the step state; no new score is
// taken until it has been applied. After the last pair of a one-versus-one
// example a scan visits every class counter in use, one per cycle
// (class_count saturated to 2..16); the finish state then moves the result
// into the output register. In one-versus-rest mode there is no scan.
// The output register decouples the sides: while a result waits for
// rsp_ready, the next scores are still taken; only the handoff of the next
// result waits until the output register is free.
// Reset (synchronous, active high) sets mode to one-versus-one, class_count
// to 2, and clears all votes and counters. Any register write discards a
// partial example. Registers: mode at address 0, class_count at address 4.
// ----------------------------------------------------------------------------
module multiclass_vote_combiner
   import mcv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // Score channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [SCORE_PORT_W-1:0] req_score,
   // Result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RESULT_W-1:0]     rsp_winner,
   output logic [RESULT_W-1:0]     rsp_top_votes,
   // Configuration port
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]   csr_prdata,
   output logic                    csr_pready
);

   logic                 mode_ff, mode_in;
   logic [CLS_CFG_W-1:0] class_count_ff, class_count_in;
   logic                 csr_write;
   logic                 reg_index;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The port never inserts wait states, so a write lands in its access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_index  = csr_paddr[2];

   always_comb begin
      mode_in        = mode_ff;
      class_count_in = class_count_ff;
      if (csr_write) begin
         case (reg_index)
            REG_MODE:        mode_in        = csr_pwdata[0];
            REG_CLASS_COUNT: class_count_in = csr_pwdata[CLS_CFG_W-1:0];
            default:         mode_in        = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_ONE_VS_ONE;
         class_count_ff <= CLS_CFG_W'(2);
      end else begin
         mode_ff        <= mode_in;
         class_count_ff <= class_count_in;
      end
   end

   // Reads return the addressed register, zero-extended to the bus width.
   always_comb begin
      case (reg_index)
         REG_MODE:        csr_prdata = CSR_DATA_W'(mode_ff);
         REG_CLASS_COUNT: csr_prdata = CSR_DATA_W'(class_count_ff);
         default:         csr_prdata = '0;
      endcase
   end

   mcv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcv_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .mode          (mode_ff),
      .class_count   (class_count_ff),
      .cfg_clear     (csr_write),
      .req_score     (req_score),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_winner    (rsp_winner),
      .rsp_top_votes (rsp_top_votes)
   );

endmodule

// File: dv/vote_label_checker.sv
// ----------------------------------------------------------------------------
// vote_label_checker
// Predicts the class label of each example and checks the result channel.
// ----------------------------------------------------------------------------
// Follows register writes and accepted scores to keep its own copy of the
// running maximum and the vote store. Every result transaction is compared,
// field by field, with the oldest predicted label. It reports the number of
// errors and the number of labels still outstanding to the testbench top.
// ----------------------------------------------------------------------------
module vote_label_checker
   import mcv_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [SCORE_PORT_W-1:0] req_score,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [RESULT_W-1:0]     rsp_winner,
   input  logic [RESULT_W-1:0]     rsp_top_votes,
   input  logic                    csr_psel,
   input  logic                    csr_penable,
   input  logic                    csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [CSR_DATA_W-1:0]   csr_pwdata,
   input  logic                    csr_pready,
   output int                      error_count,
   output int                      pending_results
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR  = CSR_ADDR_W'(REG_MODE) << 2;
   localparam logic [CSR_ADDR_W-1:0] CLASS_ADDR = CSR_ADDR_W'(REG_CLASS_COUNT) << 2;

   typedef struct packed {
      logic [RESULT_W-1:0] winner;
      logic [RESULT_W-1:0] top_votes;
   } class_label_type;

   logic                         mode_sel;
   logic [CLS_CFG_W-1:0]         class_cfg;
   logic [VOTE_W-1:0]            vote_tally [MAX_CLASSES];
   int unsigned                  pair_row;
   int unsigned                  pair_col;
   int unsigned                  score_index;
   int unsigned                  lead_class;
   logic signed [SCORE_BITS-1:0] lead_score;
   class_label_type              expected_labels [$];

   function automatic void restart_example();
      foreach (vote_tally[i]) vote_tally[i] = '0;
      pair_row    = 0;
      pair_col    = 1;
      lead_score  = '0;
      lead_class  = 0;
      score_index = 0;
   endfunction

   // Register values outside 2..MAX_CLASSES saturate.
   function automatic int unsigned active_classes();
      if (class_cfg < 2) return 2;
      if (class_cfg > MAX_CLASSES) return MAX_CLASSES;
      return int'(class_cfg);
   endfunction

   // Applies one score; returns 1 when it completes an example.
   function automatic bit tally_score(input logic signed [SCORE_BITS-1:0] score,
                                      output class_label_type label);
      int unsigned        n;
      logic [CLASS_W-1:0] best;
      logic [CLASS_W-1:0] target;
      int unsigned        i;
      n     = active_classes();
      label = '0;
      if (mode_sel == MODE_ONE_VS_REST) begin
         if (score_index == 0 || score > lead_score) begin
            lead_score = score;
            lead_class = score_index;
         end
         score_index++;
         if (score_index < n) return 0;
         label.winner = RESULT_W'(lead_class);
         restart_example();
         return 1;
      end
      // A zero score counts as a vote for the higher class of the pair.
      target = (score > 0) ? CLASS_W'(pair_row) : CLASS_W'(pair_col);
      vote_tally[target]++;
      pair_col++;
      if (pair_col < n) return 0;
      pair_row++;
      pair_col = pair_row + 1;
      if (pair_col < n) return 0;
      best = '0;
      for (i = 1; i < n; i++) begin
         if (vote_tally[CLASS_W'(i)] > vote_tally[best]) best = CLASS_W'(i);
      end
      label.winner    = RESULT_W'(best);
      label.top_votes = RESULT_W'(vote_tally[best]);
      restart_example();
      return 1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] vote checker: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      class_label_type label;
      class_label_type want;
      if (reset) begin
         mode_sel    = MODE_ONE_VS_ONE;
         class_cfg   = CLS_CFG_W'(2);
         error_count = 0;
         restart_example();
         expected_labels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == MODE_ADDR) begin
               mode_sel = csr_pwdata[0];
               restart_example();
            end else if (csr_paddr == CLASS_ADDR) begin
               class_cfg = csr_pwdata[CLS_CFG_W-1:0];
               restart_example();
            end
         end
         if (req_valid && req_ready) begin
            if (tally_score(signed'(req_score[SCORE_BITS-1:0]), label))
               expected_labels.push_back(label);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_labels.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding (winner %0h, votes %0h)",
                                         rsp_winner, rsp_top_votes));
            end else begin
               want = expected_labels.pop_front();
               if (rsp_winner !== want.winner)
                  report_mismatch($sformatf("winner %0h, predicted %0h",
                                            rsp_winner, want.winner));
               if (rsp_top_votes !== want.top_votes)
                  report_mismatch($sformatf("top_votes %0h, predicted %0h",
                                            rsp_top_votes, want.top_votes));
            end
         end
      end
      pending_results = expected_labels.size();
   end

endmodule

// File: dv/multiclass_vote_combiner_tb.sv
// ----------------------------------------------------------------------------
// multiclass_vote_combiner_tb
// Stimulus and verdict for the multiclass vote combiner.
// ----------------------------------------------------------------------------
// A short directed sequence hits the score extremes, both modes, ties, zero
// scores, class count saturation and a register write that discards a
// partial example. Random phases follow, each with its own mode and class
// count, sending whole examples with random content plus some cut-short
// examples. A separate checker predicts every label and counts errors.
// ----------------------------------------------------------------------------
module multiclass_vote_combiner_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mcv_pkg::*;

   localparam int CLOCK_HALF       = 4;
   localparam int RESET_CYCLES     = 9;
   // Longest internal activity after the last score: the apply step, a
   // full scan of the vote store and the handoff, with margin.
   localparam int SETTLE_CYCLES    = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 300000;
   localparam int ITEM_TARGET      = 1100;

   localparam logic [CSR_ADDR_W-1:0] MODE_ADDR  = CSR_ADDR_W'(REG_MODE) << 2;
   localparam logic [CSR_ADDR_W-1:0] CLASS_ADDR = CSR_ADDR_W'(REG_CLASS_COUNT) << 2;

   // How the scores of one example lean. With every score positive the lower
   // class of each pair wins, with none positive the higher one does.
   typedef enum {
      BIAS_MIXED,
      BIAS_LOW_WINS,
      BIAS_HIGH_WINS
   } vote_bias_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [SCORE_PORT_W-1:0] req_score;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [RESULT_W-1:0]     rsp_winner;
   logic [RESULT_W-1:0]     rsp_top_votes;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CSR_ADDR_W-1:0]   csr_paddr;
   logic [CSR_DATA_W-1:0]   csr_pwdata;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int fail_count;
   int results_due;
   int items_sent;
   int burst_left;
   bit gapless;
   // Set by the stimulus to ask the receiver for one long hold-off; the
   // receiver clears it once the hold-off is over.
   bit long_hold_req;

   multiclass_vote_combiner u_dut (.*);

   vote_label_checker u_checker (
      .error_count    (fail_count),
      .pending_results(results_due),
      .*
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // Every task below is entered and left at a falling clock edge, which is
   // where all inputs of the block change.

   // One register write: a setup cycle, then the access cycle that ends at
   // the rising edge where pready is seen high.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Writes both registers. The bits above each register's width carry
   // random noise, since the block must ignore them.
   task automatic configure(input logic m, input logic [CLS_CFG_W-1:0] count);
      logic [CSR_DATA_W-1:0] noise;
      noise = $urandom;
      write_reg(MODE_ADDR, {noise[CSR_DATA_W-1:1], m});
      noise = $urandom;
      write_reg(CLASS_ADDR, {noise[CSR_DATA_W-1:CLS_CFG_W], count});
   endtask

   // Stops sending and waits until every predicted label has come out. A
   // trailing score may produce no label, so the block gets extra cycles to
   // finish with it before anything else happens, such as a register write.
   task automatic settle();
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Offers one score and holds it until the block takes it. The sender then
   // either goes straight on with its burst or drops valid for a random gap.
   task automatic send_score(input logic [SCORE_PORT_W-1:0] value);
      int gap;
      req_valid <= 1'b1;
      req_score <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = gapless ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(0, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Random score. Zero, the extremes and small values near zero are
   // frequent so that zero votes and ties in the running maximum show up;
   // the rest is uniform over all 32 bits.
   function automatic logic [SCORE_PORT_W-1:0] pick_score(input vote_bias_type bias);
      logic [SCORE_PORT_W-1:0] s;
      case ($urandom_range(0, 9))
         0: begin
            s = '0;
         end
         1: begin
            case ($urandom_range(0, 3))
               0:       s = 32'h7FFF_FFFF;
               1:       s = 32'h8000_0000;
               2:       s = 32'h0000_0001;
               default: s = '1;
            endcase
         end
         2, 3: begin
            s = SCORE_PORT_W'($urandom_range(0, 6)) - SCORE_PORT_W'(3);
         end
         default: begin
            s = $urandom;
         end
      endcase
      if (bias == BIAS_LOW_WINS) begin
         s[SCORE_PORT_W-1] = 1'b0;
         if (s == '0) s = SCORE_PORT_W'(1);
      end else if (bias == BIAS_HIGH_WINS && s != '0) begin
         s[SCORE_PORT_W-1] = 1'b1;
      end
      return s;
   endfunction

   // Number of scores in one example, with the class count saturated the
   // way the block does it.
   function automatic int example_length(input logic m, input logic [CLS_CFG_W-1:0] count);
      int n;
      n = (count < 2) ? 2 : (count > MAX_CLASSES) ? MAX_CLASSES : int'(count);
      return (m == MODE_ONE_VS_ONE) ? n * (n - 1) / 2 : n;
   endfunction

   task automatic send_example(input int length, input vote_bias_type bias);
      repeat (length) send_score(pick_score(bias));
   endtask

   // One random phase: new settings, a run of whole examples and, when asked,
   // a cut-short example that the next register write throws away.
   task automatic run_phase(input logic m, input logic [CLS_CFG_W-1:0] count,
                            input int examples, input bit broken);
      int length;
      vote_bias_type bias;
      settle();
      configure(m, count);
      length = example_length(m, count);
      repeat (examples) begin
         case ($urandom_range(0, 9))
            0:       bias = BIAS_LOW_WINS;
            1:       bias = BIAS_HIGH_WINS;
            default: bias = BIAS_MIXED;
         endcase
         send_example(length, bias);
         // Now and then the sender waits for the block to drain completely.
         if ($urandom_range(0, 11) == 0) settle();
      end
      if (broken && length > 1) send_example($urandom_range(1, length - 1), BIAS_MIXED);
   endtask

   // Receiver. It follows a random 16-bit ready pattern that is replaced
   // at random times; a quarter of the patterns are all ones, giving
   // stretches with no stall at all. On request it holds off for a long
   // stretch so that the block backs up and stalls its input.
   initial begin
      logic [15:0] stall_pattern;
      int          pattern_left;
      int unsigned pattern_pos;
      rsp_ready     = 1'b0;
      stall_pattern = '1;
      pattern_left  = 0;
      pattern_pos   = 0;
      do @(negedge clock); while (reset);
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
            long_hold_req = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               stall_pattern = $urandom;
               if ($urandom_range(0, 3) == 0) stall_pattern = '1;
               pattern_left  = $urandom_range(16, 64);
            end
            rsp_ready   <= stall_pattern[pattern_pos % 16];
            pattern_pos <= pattern_pos + 1;
            pattern_left--;
         end
      end
   end

   // Watchdog: a correct run ends far below this many cycles.
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("multiclass_vote_combiner: mismatch");
      $finish;
   end

   initial begin
      logic                 m;
      logic [CLS_CFG_W-1:0] count;
      int                   examples;
      int                   pick;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_score     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      items_sent    = 0;
      burst_left    = 0;
      gapless       = 1'b0;
      long_hold_req = 1'b0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: one-versus-one with two classes, so every score is
      // a complete example. Zero votes for the higher class, as does -1 and
      // the most negative score; 1 and the most positive vote for class 0.
      send_score('0);
      send_score(32'h0000_0001);
      send_score('1);
      send_score(32'h7FFF_FFFF);
      send_score(32'h8000_0000);

      // One-versus-rest with two classes: both orders of the extremes, then
      // a tie, which goes to the lower class.
      settle();
      configure(MODE_ONE_VS_REST, 2);
      send_score(32'h7FFF_FFFF);
      send_score(32'h8000_0000);
      send_score(32'h8000_0000);
      send_score(32'h7FFF_FFFF);
      send_score(32'h0000_0005);
      send_score(32'h0000_0005);

      // A class count of zero saturates to two. The first score is taken as
      // the maximum even when it is the most negative value.
      settle();
      configure(MODE_ONE_VS_REST, 0);
      send_score(32'h8000_0000);
      send_score(32'h8000_0000);

      // Three classes: the maximum sits in the middle and is tied later on.
      settle();
      configure(MODE_ONE_VS_REST, 3);
      send_score(32'h0000_0001);
      send_score(32'h0000_0002);
      send_score(32'h0000_0002);

      // Three classes voting: pairs (0,1) (0,2) (1,2) give one vote to each
      // class, and the three-way tie goes to class 0.
      settle();
      configure(MODE_ONE_VS_ONE, 3);
      send_score(32'h0000_0001);
      send_score('0);
      send_score(32'h0000_0001);

      // A partial example is dropped by a register write; the next example
      // starts again at pair (0,1) with an empty vote store.
      send_score('1);
      settle();
      configure(MODE_ONE_VS_ONE, 3);
      send_score('1);
      send_score('1);
      send_score('1);

      // Back-pressure: two-score examples sent without gaps while the
      // receiver holds off, so the output register fills and the block
      // stops taking scores until the receiver comes back.
      settle();
      configure(MODE_ONE_VS_REST, 2);
      gapless       = 1'b1;
      long_hold_req = 1'b1;
      repeat (60) send_example(2, BIAS_MIXED);
      gapless       = 1'b0;

      // Largest vote store: with no positive score class k gets k votes,
      // so class 15 wins with 15 votes and every result bit is set.
      settle();
      configure(MODE_ONE_VS_ONE, 16);
      send_example(example_length(MODE_ONE_VS_ONE, 16), BIAS_HIGH_WINS);

      // Largest register value, which saturates to sixteen classes.
      run_phase(MODE_ONE_VS_REST, 31, 4, 1'b1);

      // Random phases. Small class counts dominate so that labels come
      // often; large voting examples are kept rare because they are long.
      while (items_sent < ITEM_TARGET) begin
         m    = $urandom_range(0, 1) ? MODE_ONE_VS_ONE : MODE_ONE_VS_REST;
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            count = $urandom_range(2, 5);
         end else if (pick < 17) begin
            count = $urandom_range(6, 9);
         end else if (pick < 19) begin
            count = $urandom_range(0, 1);
         end else begin
            count = $urandom_range(16, 31);
            m     = MODE_ONE_VS_REST;
         end
         examples = (m == MODE_ONE_VS_ONE && count > 5) ? $urandom_range(1, 3)
                                                        : $urandom_range(2, 10);
         gapless  = ($urandom_range(0, 4) == 0);
         run_phase(m, count, examples, $urandom_range(0, 3) == 0);
      end
      gapless = 1'b0;

      settle();
      if (fail_count == 0) begin
         $display("multiclass_vote_combiner: match");
      end else begin
         $display("multiclass_vote_combiner: mismatch");
      end
      $finish;
   end

endmodule
